// ===== design/sdaxis_pkg.sv =====
// Shared types and constants for the step/direction axis block.
package sdaxis_pkg;

	// Default width of the internal step position.
	localparam int unsigned POSITION_WIDTH_DEF = 32;

	// Widths fixed by the word formats.
	localparam int unsigned POS_FIELD_W = 32;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 40;

	typedef enum logic [1:0] {
		OP_STEP  = 2'd0,
		OP_DIR   = 2'd1,
		OP_RESET = 2'd2,
		OP_OTHER = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INVERT_DIR   = 3'd0,
		REG_MOTOR_CONN   = 3'd1,
		REG_START_POS    = 3'd2,
		REG_MIN_THRESH   = 3'd3,
		REG_MAX_THRESH   = 3'd4,
		REG_ENDSTOP_EN   = 3'd5,
		REG_ENDSTOP_POL  = 3'd6,
		REG_SHARED_PIN   = 3'd7
	} reg_idx_t;

endpackage

// ===== design/step_dir_axis_with_endstops.sv =====
// Step/direction position counter with two position endstops, stream in and out.
// A word passes through the input register and then the result register.
// Throughput: one word per cycle unless m_axis_tready stalls the output; the counter update,
// saturation and the two threshold compares all fit between the input and result registers.
// Reset (arst_n low, asynchronous): position 0, stored step/dir levels 0, all config
// registers to defaults (motor on = 1, rest 0), both pipeline stages empty.
module step_dir_axis_with_endstops
	import sdaxis_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// config write port
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,

	// input words
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] op, [2] level, [7:3] zero

	// result words
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] position, [32] min_triggered,
	                                               // [33] max_triggered, [34] either_triggered,
	                                               // [35] pin_a_level, [36] pin_b_level,
	                                               // [37] pin_a_driven, [38] pin_b_driven,
	                                               // [39] zero
);

	localparam int unsigned PW = POSITION_WIDTH;
	// compare width: wide enough for both the position and the 32-bit thresholds
	localparam int unsigned CW = (PW > POS_FIELD_W) ? PW : POS_FIELD_W;

	localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

	// ---------------- config registers ----------------
	logic                          invert_dir_q;
	logic                          motor_conn_q;
	logic signed [POS_FIELD_W-1:0] start_pos_q;
	logic signed [POS_FIELD_W-1:0] min_thresh_q;
	logic signed [POS_FIELD_W-1:0] max_thresh_q;
	logic [1:0]                    endstop_en_q;
	logic [3:0]                    endstop_pol_q;
	logic                          shared_pin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_dir_q  <= 1'b0;
			motor_conn_q  <= 1'b1;
			start_pos_q   <= '0;
			min_thresh_q  <= '0;
			max_thresh_q  <= '0;
			endstop_en_q  <= '0;
			endstop_pol_q <= '0;
			shared_pin_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INVERT_DIR:  invert_dir_q  <= cfg_wdata[0];
				REG_MOTOR_CONN:  motor_conn_q  <= cfg_wdata[0];
				REG_START_POS:   start_pos_q   <= cfg_wdata;
				REG_MIN_THRESH:  min_thresh_q  <= cfg_wdata;
				REG_MAX_THRESH:  max_thresh_q  <= cfg_wdata;
				REG_ENDSTOP_EN:  endstop_en_q  <= cfg_wdata[1:0];
				REG_ENDSTOP_POL: endstop_pol_q <= cfg_wdata[3:0];
				REG_SHARED_PIN:  shared_pin_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic valid_s1;
	op_t  op_s1;
	logic level_s1;
	logic valid_s2;
	logic adv_s1;      // stage 1 word moves into the result register

	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (m_axis_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= op_t'(s_axis_tdata[1:0]);
			level_s1 <= s_axis_tdata[2];
		end
	end

	// ---------------- axis state ----------------
	logic signed [PW-1:0] count_q;
	logic                 last_step_q;
	logic                 last_dir_q;

	logic signed [PW-1:0] count_nxt;
	logic                 last_step_nxt;
	logic                 last_dir_nxt;
	logic signed [CW-1:0] start_ext;
	logic signed [PW-1:0] start_clamped;

	// start position clamped into the position range (only bites when PW < 32)
	always_comb begin
		start_ext = CW'(start_pos_q);
		if (start_ext > CW'(POS_MAX))
			start_clamped = POS_MAX;
		else if (start_ext < CW'(POS_MIN))
			start_clamped = POS_MIN;
		else
			start_clamped = start_ext[PW-1:0];
	end

	always_comb begin
		count_nxt     = count_q;
		last_step_nxt = last_step_q;
		last_dir_nxt  = last_dir_q;
		case (op_s1)
			OP_STEP: begin
				last_step_nxt = level_s1;
				if (level_s1 && !last_step_q && motor_conn_q) begin
					if (last_dir_q ^ invert_dir_q) begin
						if (count_q != POS_MIN)
							count_nxt = count_q - PW'(1);
					end else begin
						if (count_q != POS_MAX)
							count_nxt = count_q + PW'(1);
					end
				end
			end
			OP_DIR:   last_dir_nxt = level_s1;
			OP_RESET: begin
				count_nxt     = start_clamped;
				last_step_nxt = 1'b0;
				last_dir_nxt  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_step_q <= 1'b0;
			last_dir_q  <= 1'b0;
		end else if (adv_s1) begin
			count_q     <= count_nxt;
			last_step_q <= last_step_nxt;
			last_dir_q  <= last_dir_nxt;
		end
	end

	// ---------------- endstops on the updated position ----------------
	logic signed [CW-1:0] count_ext;
	logic                 trig_a, trig_b;
	logic                 pol_sel;
	logic                 pa_lvl, pb_lvl, pa_drv, pb_drv;

	assign count_ext = CW'(count_nxt);

	always_comb begin
		trig_a = 1'b0;
		trig_b = 1'b0;
		if (endstop_en_q[0])
			trig_a = !motor_conn_q || (endstop_pol_q[0] ? (count_ext >= CW'(min_thresh_q))
			                                             : (count_ext <= CW'(min_thresh_q)));
		if (endstop_en_q[1])
			trig_b = !motor_conn_q || (endstop_pol_q[1] ? (count_ext >= CW'(max_thresh_q))
			                                             : (count_ext <= CW'(max_thresh_q)));

		// shared pin: B's polarity wins when B is on
		pol_sel = endstop_en_q[1] ? endstop_pol_q[3] : endstop_pol_q[2];
		pa_lvl  = 1'b0;
		pb_lvl  = 1'b0;
		pa_drv  = 1'b0;
		pb_drv  = 1'b0;
		if (shared_pin_q) begin
			if (|endstop_en_q) begin
				pa_drv = 1'b1;
				pa_lvl = (trig_a || trig_b) ? pol_sel : !pol_sel;
			end
		end else begin
			if (endstop_en_q[0]) begin
				pa_drv = 1'b1;
				pa_lvl = trig_a ? endstop_pol_q[2] : !endstop_pol_q[2];
			end
			if (endstop_en_q[1]) begin
				pb_drv = 1'b1;
				pb_lvl = trig_b ? endstop_pol_q[3] : !endstop_pol_q[3];
			end
		end
	end

	// ---------------- result register ----------------
	logic [POS_FIELD_W-1:0] pos_s2;
	logic [6:0]             flags_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pos_s2   <= count_ext[POS_FIELD_W-1:0];
			flags_s2 <= {pb_drv, pa_drv, pb_lvl, pa_lvl, trig_a || trig_b, trig_b, trig_a};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, flags_s2, pos_s2};

`ifndef NO_ASSERTIONS
	// position only moves when a word passes into the result register
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(count_q))
		else $error("position changed without a word");

	// a full stage 1 behind a stalled result must block the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while pipeline is full");

	// shared pin mode never drives pin B
	a_shared_b_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && shared_pin_q |=> !flags_s2[6] && !flags_s2[4])
		else $error("pin B driven in shared mode");

	// combined trigger flag is the OR of the two stop flags
	a_any_trig: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> flags_s2[2] == (flags_s2[0] || flags_s2[1]))
		else $error("combined trigger flag mismatch");
`endif

endmodule
